// File: hdl/tcp_health_check_engine_core_defines.svh
// Assertion macros used by the engine's control module.
`ifndef TCP_HEALTH_CHECK_ENGINE_CORE_DEFINES_SVH
`define TCP_HEALTH_CHECK_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HCE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCE_ASSERT(lbl, clk, rst_n, prop, msg)
`define HCE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hdl/hce_pkg.sv
package hce_pkg;
	localparam int MAX_SERVERS_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 24;
	localparam int PADDR_W = 4;

	localparam logic [23:0] INTERVAL_RST = 24'd3;
	localparam logic [23:0] TIMEOUT_RST  = 24'd1;
	localparam logic [31:0] SEQ_RST      = 32'd9999;

	localparam logic [1:0] REG_INTERVAL = 2'd0;
	localparam logic [1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [1:0] REG_SEQ      = 2'd2;

	localparam logic [1:0] ACT_ADD    = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_REPLY  = 2'd2;
	localparam logic [1:0] ACT_TICK   = 2'd3;

	localparam logic [1:0] KIND_STATUS  = 2'd0;
	localparam logic [1:0] KIND_SYN     = 2'd1;
	localparam logic [1:0] KIND_RST     = 2'd2;
	localparam logic [1:0] KIND_TIMEOUT = 2'd3;

	localparam logic [1:0] CODE_OK       = 2'd0;
	localparam logic [1:0] CODE_EXISTS   = 2'd1;
	localparam logic [1:0] CODE_NOTFOUND = 2'd2;
	localparam logic [1:0] CODE_FULL     = 2'd3;

	localparam logic [1:0] H_UNKNOWN = 2'd0;
	localparam logic [1:0] H_HEALTHY = 2'd1;
	localparam logic [1:0] H_FAILED  = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic        is_udp;
		logic [31:0] server_ip;
		logic [15:0] server_port;
		logic        flag_rst;
		logic        flag_syn;
		logic        flag_ack;
		logic [31:0] reply_seq;
		logic [31:0] reply_ack_num;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  code;
		logic [31:0] dest_ip;
		logic [15:0] dest_port;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic [1:0]  health;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic next;
		logic scan;
		logic tick_step;
		logic finish;
		logic push_pend;
		logic push_second;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic last_idx;
		logic fire;
		logic pend_valid;
		logic can_push;
		logic two_results;
	} stat_t;
endpackage

// File: hdl/hce_ram.sv
module hce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hdl/hce_dp.sv
module hce_dp #(
	parameter int MAX_SERVERS = hce_pkg::MAX_SERVERS_DEF,
	parameter int COUNT_WIDTH = hce_pkg::COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hce_pkg::cmd_t     cmd,
	output hce_pkg::stat_t    st,
	input  hce_pkg::req_t     req,
	input  logic [23:0]       interval,
	input  logic [23:0]       timeout,
	input  logic [31:0]       probe_seq,
	output hce_pkg::rsp_t     rsp,
	output logic              rsp_valid,
	input  logic              rsp_ready
);
	localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CW = COUNT_WIDTH;
	localparam int EW = CW + 52;

	hce_pkg::req_t    item_q;
	logic [IDX_W-1:0] idx_q;
	logic [MAX_SERVERS-1:0] valid_q;
	logic             match_found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [1:0]       match_health_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             pend_valid_q;
	hce_pkg::rsp_t    pend_q;
	logic             rsp_valid_q;
	hce_pkg::rsp_t    rsp_q;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [EW-1:0]    wdata;
	logic [EW-1:0]    rdata;

	logic             rd_udp;
	logic [31:0]      rd_ip;
	logic [15:0]      rd_port;
	logic [1:0]       rd_health;
	logic             rd_await;
	logic [CW-1:0]    rd_cd;
	logic [31:0]      int_ext;
	logic [31:0]      tmo_ext;
	logic [CW-1:0]    cd_int;
	logic [CW-1:0]    cd_tmo;
	logic             key_udp;
	logic             cur_valid;
	logic             hit;
	logic             live;
	logic             expire;
	logic             can_push;
	logic             is_reply;
	logic             two;
	hce_pkg::rsp_t    tick_res;
	hce_pkg::rsp_t    fin_res;
	logic             fin_we;
	logic [IDX_W-1:0] fin_addr;
	logic [1:0]       fin_health;

	hce_ram #(.WIDTH(EW), .DEPTH(MAX_SERVERS), .AW(IDX_W)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(idx_q), .rdata(rdata)
	);

	assign rd_cd     = rdata[CW-1:0];
	assign rd_await  = rdata[CW];
	assign rd_health = rdata[CW+2:CW+1];
	assign rd_port   = rdata[CW+18:CW+3];
	assign rd_ip     = rdata[CW+50:CW+19];
	assign rd_udp    = rdata[CW+51];

	assign int_ext = {8'd0, interval};
	assign tmo_ext = {8'd0, timeout};
	assign cd_int  = int_ext[CW-1:0];
	assign cd_tmo  = tmo_ext[CW-1:0];

	assign is_reply  = item_q.action == hce_pkg::ACT_REPLY;
	assign key_udp   = is_reply ? 1'b0 : item_q.is_udp;
	assign cur_valid = valid_q[idx_q];
	assign hit = cur_valid && rd_udp == key_udp && rd_ip == item_q.server_ip
		&& rd_port == item_q.server_port;
	assign live   = cur_valid && !rd_udp;
	assign expire = rd_cd <= CW'(1);
	assign can_push = !rsp_valid_q || rsp_ready;
	assign two = is_reply && match_found_q && !item_q.flag_rst && item_q.flag_syn
		&& item_q.flag_ack;

	always_comb begin
		tick_res.kind      = rd_await ? hce_pkg::KIND_TIMEOUT : hce_pkg::KIND_SYN;
		tick_res.code      = hce_pkg::CODE_OK;
		tick_res.dest_ip   = rd_ip;
		tick_res.dest_port = rd_port;
		tick_res.seg_seq   = rd_await ? 32'd0 : probe_seq;
		tick_res.seg_ack   = 32'd0;
		tick_res.health    = rd_await ? hce_pkg::H_FAILED : rd_health;
		tick_res.last      = 1'b0;
	end

	always_comb begin
		fin_res.kind      = hce_pkg::KIND_STATUS;
		fin_res.code      = hce_pkg::CODE_OK;
		fin_res.dest_ip   = item_q.server_ip;
		fin_res.dest_port = item_q.server_port;
		fin_res.seg_seq   = 32'd0;
		fin_res.seg_ack   = 32'd0;
		fin_res.health    = hce_pkg::H_UNKNOWN;
		fin_res.last      = !two;
		fin_we     = 1'b0;
		fin_addr   = match_idx_q;
		fin_health = hce_pkg::H_UNKNOWN;
		case (item_q.action)
			hce_pkg::ACT_ADD: begin
				if (match_found_q) begin
					fin_res.code   = hce_pkg::CODE_EXISTS;
					fin_res.health = match_health_q;
				end else if (!free_found_q) begin
					fin_res.code = hce_pkg::CODE_FULL;
				end else begin
					fin_we   = 1'b1;
					fin_addr = free_idx_q;
				end
			end
			hce_pkg::ACT_REMOVE: begin
				if (!match_found_q) begin
					fin_res.code = hce_pkg::CODE_NOTFOUND;
				end
			end
			hce_pkg::ACT_REPLY: begin
				if (!match_found_q) begin
					fin_res.code = hce_pkg::CODE_NOTFOUND;
				end else if (item_q.flag_rst) begin
					fin_we         = 1'b1;
					fin_health     = hce_pkg::H_FAILED;
					fin_res.health = hce_pkg::H_FAILED;
				end else if (two) begin
					fin_we         = 1'b1;
					fin_health     = hce_pkg::H_HEALTHY;
					fin_res.health = hce_pkg::H_HEALTHY;
				end else begin
					fin_res.health = match_health_q;
				end
			end
			default: begin
				fin_res.code = hce_pkg::CODE_OK;
			end
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata;
		if (cmd.tick_step && live) begin
			we = 1'b1;
			if (!expire) begin
				wdata = {rd_udp, rd_ip, rd_port, rd_health, rd_await, rd_cd - CW'(1)};
			end else if (!rd_await) begin
				wdata = {rd_udp, rd_ip, rd_port, rd_health, 1'b1, cd_tmo};
			end else begin
				wdata = {rd_udp, rd_ip, rd_port, hce_pkg::H_FAILED, 1'b0, cd_int};
			end
		end else if (cmd.finish && fin_we) begin
			we    = 1'b1;
			waddr = fin_addr;
			wdata = {key_udp, item_q.server_ip, item_q.server_port, fin_health, 1'b0,
				cd_int};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
		if (cmd.scan && hit && !match_found_q) begin
			match_idx_q    <= idx_q;
			match_health_q <= rd_health;
		end
		if (cmd.scan && !cur_valid && !free_found_q) begin
			free_idx_q <= idx_q;
		end
		if (cmd.tick_step && live && expire) begin
			pend_q <= tick_res;
		end
		if (cmd.finish) begin
			rsp_q <= fin_res;
		end else if (cmd.push_second) begin
			rsp_q.kind      <= hce_pkg::KIND_RST;
			rsp_q.code      <= hce_pkg::CODE_OK;
			rsp_q.dest_ip   <= item_q.server_ip;
			rsp_q.dest_port <= item_q.server_port;
			rsp_q.seg_seq   <= item_q.reply_ack_num + 32'd1;
			rsp_q.seg_ack   <= item_q.reply_seq + 32'd1;
			rsp_q.health    <= hce_pkg::H_HEALTHY;
			rsp_q.last      <= 1'b1;
		end else if (cmd.push_pend) begin
			rsp_q      <= pend_q;
			rsp_q.last <= 1'b1;
		end else if (cmd.tick_step && live && expire && pend_valid_q) begin
			rsp_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			valid_q       <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			pend_valid_q  <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q         <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				pend_valid_q  <= 1'b0;
			end else if (cmd.next) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.scan && hit) begin
				match_found_q <= 1'b1;
			end
			if (cmd.scan && !cur_valid) begin
				free_found_q <= 1'b1;
			end
			if (cmd.tick_step && live && expire) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.push_pend) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.finish && item_q.action == hce_pkg::ACT_ADD && fin_we) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (cmd.finish && item_q.action == hce_pkg::ACT_REMOVE && match_found_q) begin
				valid_q[match_idx_q] <= 1'b0;
			end
			if (cmd.finish || cmd.push_second || cmd.push_pend
				|| (cmd.tick_step && live && expire && pend_valid_q)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign st.is_tick     = item_q.action == hce_pkg::ACT_TICK;
	assign st.last_idx    = idx_q == IDX_W'(MAX_SERVERS - 1);
	assign st.fire        = live && expire;
	assign st.pend_valid  = pend_valid_q;
	assign st.can_push    = can_push;
	assign st.two_results = two;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;
endmodule

// File: hdl/hce_ctrl.sv
`include "tcp_health_check_engine_core_defines.svh"

module hce_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  hce_pkg::stat_t st,
	output hce_pkg::cmd_t  cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_FIN1 = 3'd3;
	localparam logic [2:0] S_FIN2 = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign req_ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				if (!st.is_tick) begin
					cmd.scan = 1'b1;
				end
				// A firing entry has to hand the held result on before it takes its place.
				if (st.is_tick && st.fire && st.pend_valid && !st.can_push) begin
					state_d = S_CHK;
				end else begin
					cmd.tick_step = st.is_tick;
					if (st.last_idx) begin
						state_d = S_FIN1;
					end else begin
						cmd.next = 1'b1;
						state_d  = S_RD;
					end
				end
			end
			S_FIN1: begin
				if (st.is_tick) begin
					if (!st.pend_valid) begin
						state_d = S_IDLE;
					end else if (st.can_push) begin
						cmd.push_pend = 1'b1;
						state_d       = S_IDLE;
					end
				end else if (st.can_push) begin
					cmd.finish = 1'b1;
					state_d    = st.two_results ? S_FIN2 : S_IDLE;
				end
			end
			S_FIN2: begin
				if (st.can_push) begin
					cmd.push_second = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`HCE_ASSERT(a_push_room, clk, arst_n, (cmd.finish || cmd.push_second || cmd.push_pend) |-> st.can_push, "result pushed over an unaccepted item")
	`HCE_ASSERT(a_tick_push_room, clk, arst_n, (cmd.tick_step && st.fire && st.pend_valid) |-> st.can_push, "held tick result lost")
	`HCE_ASSERT(a_one_push, clk, arst_n, $onehot0({cmd.finish, cmd.push_second, cmd.push_pend}), "two results pushed at once")
	`HCE_ASSERT(a_second_follows, clk, arst_n, cmd.push_second |-> $past(state_q) == S_FIN1 || $past(state_q) == S_FIN2, "reset segment without its status")
endmodule

// File: hdl/tcp_health_check_engine_core.sv
// Health-check engine for up to MAX_SERVERS backend servers. Each request item (add, remove,
// probe reply or tick) is handled by a scan of the whole entry table held in a RAM with one
// read and one write port, entry by entry (read, then check and write back), then by the issue
// of the final results, which the result side can hold off. A tick yields one result item per
// firing TCP entry, in table order, and none when nothing fires; every other action yields one
// status item, and a SYN-ACK reply to a known server adds an RST item after it. The last result
// of each request carries last. Registers at 0x0, 0x4 and 0x8 set the probe interval, reply
// timeout and SYN sequence number, and should be written only while the engine is idle.
module tcp_health_check_engine_core #(
	parameter int MAX_SERVERS = hce_pkg::MAX_SERVERS_DEF,
	parameter int COUNT_WIDTH = hce_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  hce_pkg::req_t               req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output hce_pkg::rsp_t               rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hce_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	logic [23:0]    interval_q;
	logic [23:0]    timeout_q;
	logic [31:0]    seq_q;
	logic [1:0]     reg_idx;
	hce_pkg::cmd_t  cmd;
	hce_pkg::stat_t st;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= hce_pkg::INTERVAL_RST;
			timeout_q  <= hce_pkg::TIMEOUT_RST;
			seq_q      <= hce_pkg::SEQ_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				hce_pkg::REG_INTERVAL: interval_q <= pwdata[23:0];
				hce_pkg::REG_TIMEOUT:  timeout_q  <= pwdata[23:0];
				hce_pkg::REG_SEQ:      seq_q      <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			hce_pkg::REG_INTERVAL: prdata = {8'd0, interval_q};
			hce_pkg::REG_TIMEOUT:  prdata = {8'd0, timeout_q};
			hce_pkg::REG_SEQ:      prdata = seq_q;
			default:               prdata = 32'd0;
		endcase
	end

	hce_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_ready(req_ready),
		.st(st), .cmd(cmd)
	);

	hce_dp #(.MAX_SERVERS(MAX_SERVERS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st), .req(req),
		.interval(interval_q), .timeout(timeout_q), .probe_seq(seq_q),
		.rsp(rsp), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready)
	);
endmodule
